[design/prime_list_by_stored_primes_assert.svh]
// ----------------------------------------------------------------------------
// prime list assertion macros
// concurrent checks on clk, disabled while rst is high; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef PRIME_LIST_BY_STORED_PRIMES_ASSERT_SVH
`define PRIME_LIST_BY_STORED_PRIMES_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PLSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plsp assertion failed");
// next-cycle implication
`define PLSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plsp assertion failed");
`else
`define PLSP_ASSERT_IMP(lbl, ante, cons)
`define PLSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/plsp_pkg.sv]
// ----------------------------------------------------------------------------
// plsp_pkg
// shared types and codes of the prime list generator
// ----------------------------------------------------------------------------
`default_nettype none

package plsp_pkg;

  // result status codes
  localparam logic [1:0] ST_PRIME   = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_DECIDE,
    S_TRY,
    S_SCAN,
    S_LOAD,
    S_DIV
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_two;
    logic       set_finished;
    logic       store_two;
    logic       next_cand;
    logic       store_c;
    logic       rd;
    logic       div_start;
    logic       k_inc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic limit_zero;
    logic finished;
    logic cand_two;
    logic limit_lt2;
    logic cand_over;
    logic scan_end;
    logic table_full;
    logic zero_divisor;
    logic div_done;
    logic rem_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[design/plsp_rem.sv]
// ----------------------------------------------------------------------------
// plsp_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "prime_list_by_stored_primes_assert.svh"

module plsp_rem #(
  parameter int W = 14
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic              rem_zero
);

  localparam int CNTW = $clog2(W);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    dvd;
  logic [W-1:0]    dsr;
  logic [W-1:0]    rem;
  logic [W-1:0]    rem_next;
  logic [W:0]      trial;

  always_comb begin
    trial = {rem, dvd[W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= CNTW'(W - 1);
    end else if (run) begin
      rem <= rem_next;
      dvd <= {dvd[W-2:0], 1'b0};
      cnt <= cnt - CNTW'(1);
    end
  end

  assign rem_zero = (rem == '0);

  // a new division never starts on top of a running one
  `PLSP_ASSERT_IMP(a_start_idle, start, !run)

endmodule

`default_nettype wire

[design/plsp_dpath.sv]
// ----------------------------------------------------------------------------
// plsp_dpath
// limit, candidate, prime table, remainder unit and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "prime_list_by_stored_primes_assert.svh"

module plsp_dpath #(
  parameter int MAX_PRIMES = 2048,
  parameter int VALUE_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire plsp_pkg::cmd_t        cmd,
  input  wire logic                  restart,
  input  wire logic                  cfg_wen,
  input  wire logic [VALUE_BITS-1:0] cfg_wdata,
  input  wire logic                  out_stall,
  output plsp_pkg::sts_t             sts,
  output logic                       out_valid,
  output logic [VALUE_BITS-1:0]      prime,
  output logic [1:0]                 status
);

  localparam int AW = $clog2(MAX_PRIMES);
  localparam int CW = $clog2(MAX_PRIMES + 1);
  localparam int DW = VALUE_BITS + 1;

  logic [VALUE_BITS-1:0] upper_limit;
  logic [DW-1:0]         candidate;
  logic [CW-1:0]         count;
  logic                  finished;
  logic [VALUE_BITS-1:0] c;
  logic [CW-1:0]         k;
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] prime_mem [MAX_PRIMES];

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  div_done;
  logic                  rem_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= '0;
      candidate   <= DW'(2);
      count       <= '0;
      finished    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        upper_limit <= cfg_wdata;
      end
      if (cmd.take && restart) begin
        count     <= '0;
        candidate <= DW'(2);
        finished  <= 1'b0;
      end
      if (cmd.set_finished) begin
        finished <= 1'b1;
      end
      if (cmd.store_two) begin
        count     <= CW'(1);
        candidate <= DW'(3);
      end
      if (cmd.next_cand) begin
        candidate <= candidate + DW'(2);
      end
      if (cmd.store_c) begin
        count <= count + CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan index, trial value and result payload
  always_ff @(posedge clk) begin
    if (cmd.next_cand) begin
      c <= candidate[VALUE_BITS-1:0];
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + CW'(1);
    end
    if (cmd.emit) begin
      status <= cmd.emit_status;
      if (cmd.emit_status != plsp_pkg::ST_PRIME) begin
        prime <= '0;
      end else if (cmd.emit_two) begin
        prime <= VALUE_BITS'(2);
      end else begin
        prime <= c;
      end
    end
  end

  // prime table, one write port and one read port
  always_comb begin
    wr_en   = cmd.store_two || cmd.store_c;
    wr_addr = cmd.store_two ? '0 : count[AW-1:0];
    wr_data = cmd.store_two ? VALUE_BITS'(2) : c;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prime_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata <= prime_mem[k[AW-1:0]];
    end
  end

  plsp_rem #(
    .W (VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (c),
    .divisor  (rdata),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  always_comb begin
    sts.limit_zero   = (upper_limit == '0);
    sts.finished     = finished;
    sts.cand_two     = (candidate == DW'(2));
    sts.limit_lt2    = (upper_limit < VALUE_BITS'(2));
    sts.cand_over    = (candidate > {1'b0, upper_limit});
    sts.scan_end     = (k >= count);
    sts.table_full   = (count >= CW'(MAX_PRIMES));
    sts.zero_divisor = (rdata == '0);
    sts.div_done     = div_done;
    sts.rem_zero     = rem_zero;
    sts.out_free     = !out_valid || !out_stall;
  end

  `PLSP_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(MAX_PRIMES))
  `PLSP_ASSERT_IMP(a_prime_nonzero, out_valid && status == plsp_pkg::ST_PRIME, prime != '0)
  `PLSP_ASSERT_NXT(a_emit_shows, cmd.emit, out_valid)

endmodule

`default_nettype wire

[design/plsp_ctrl.sv]
// ----------------------------------------------------------------------------
// plsp_ctrl
// request sequencer: decides, walks candidates and the stored primes
// ----------------------------------------------------------------------------
`default_nettype none

`include "prime_list_by_stored_primes_assert.svh"

module plsp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire plsp_pkg::sts_t sts,
  output logic                in_stall,
  output plsp_pkg::cmd_t      cmd
);

  plsp_pkg::state_t state;
  plsp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plsp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      plsp_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = plsp_pkg::S_WAIT;
        end
      end
      plsp_pkg::S_WAIT: begin
        if (sts.out_free) begin
          state_next = plsp_pkg::S_DECIDE;
        end
      end
      plsp_pkg::S_DECIDE: begin
        if (sts.limit_zero || sts.finished || sts.cand_two) begin
          state_next = plsp_pkg::S_IDLE;
        end else begin
          state_next = plsp_pkg::S_TRY;
        end
      end
      plsp_pkg::S_TRY: begin
        state_next = sts.cand_over ? plsp_pkg::S_IDLE : plsp_pkg::S_SCAN;
      end
      plsp_pkg::S_SCAN: begin
        state_next = sts.scan_end ? plsp_pkg::S_IDLE : plsp_pkg::S_LOAD;
      end
      plsp_pkg::S_LOAD: begin
        state_next = sts.zero_divisor ? plsp_pkg::S_SCAN : plsp_pkg::S_DIV;
      end
      plsp_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = sts.rem_zero ? plsp_pkg::S_TRY : plsp_pkg::S_SCAN;
        end
      end
      default: begin
        state_next = plsp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != plsp_pkg::S_IDLE);
    case (state)
      plsp_pkg::S_IDLE: begin
        cmd.take = in_valid;
      end
      plsp_pkg::S_DECIDE: begin
        if (sts.limit_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = plsp_pkg::ST_INVALID;
        end else if (sts.finished) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = plsp_pkg::ST_DONE;
        end else if (sts.cand_two) begin
          cmd.emit = 1'b1;
          if (sts.limit_lt2) begin
            cmd.set_finished = 1'b1;
            cmd.emit_status  = plsp_pkg::ST_DONE;
          end else begin
            cmd.store_two   = 1'b1;
            cmd.emit_two    = 1'b1;
            cmd.emit_status = plsp_pkg::ST_PRIME;
          end
        end
      end
      plsp_pkg::S_TRY: begin
        if (sts.cand_over) begin
          cmd.set_finished = 1'b1;
          cmd.emit         = 1'b1;
          cmd.emit_status  = plsp_pkg::ST_DONE;
        end else begin
          cmd.next_cand = 1'b1;
        end
      end
      plsp_pkg::S_SCAN: begin
        if (sts.scan_end) begin
          cmd.emit = 1'b1;
          if (sts.table_full) begin
            cmd.set_finished = 1'b1;
            cmd.emit_status  = plsp_pkg::ST_DONE;
          end else begin
            cmd.store_c     = 1'b1;
            cmd.emit_status = plsp_pkg::ST_PRIME;
          end
        end else begin
          cmd.rd = 1'b1;
        end
      end
      plsp_pkg::S_LOAD: begin
        if (sts.zero_divisor) begin
          cmd.k_inc = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      plsp_pkg::S_DIV: begin
        cmd.k_inc = sts.div_done && !sts.rem_zero;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `PLSP_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
  `PLSP_ASSERT_IMP(a_store_room, cmd.store_c, !sts.table_full)

endmodule

`default_nettype wire

[design/prime_list_by_stored_primes.sv]
// ----------------------------------------------------------------------------
// prime_list_by_stored_primes
// hands out primes up to a programmable limit, one per request beat
// ----------------------------------------------------------------------------
// Each input beat asks for the next prime (restart = 1 first clears the
// list, then serves the request), and exactly one result beat comes back:
// status 0 with the prime, status 1 with prime 0 once the list is over
// (limit passed, limit below 2, or table full), or status 2 with prime 0
// while upper_limit is zero. Odd candidates are tested by trial division
// against every prime already kept in an on-chip table of MAX_PRIMES
// entries. Timing depends on the data: a request is accepted, waits for a
// free result register and is decided, then candidates are tried one by
// one, and each is divided by every stored prime in turn, in the
// one-bit-per-cycle remainder unit fed from the single table read port.
// The result beat shows up the cycle after the decision. One request is in
// flight at a time; the result register lets the next request be taken
// while the previous result beat is still stalled. upper_limit may only be
// written while no request is in progress. No table clearing is needed after
// reset: only entries below the stored count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_list_by_stored_primes #(
  parameter int MAX_PRIMES = 2048,
  parameter int VALUE_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // upper_limit register write
  input  wire logic                  cfg_wen,
  input  wire logic [VALUE_BITS-1:0] cfg_wdata,
  // request beats
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  restart,
  // result beats
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VALUE_BITS-1:0]      prime,
  output logic [1:0]                 status
);

  // command and status between sequencer and datapath
  plsp_pkg::cmd_t cmd;
  plsp_pkg::sts_t sts;

  // sequencer: idle, wait for free result register, decide, walk table
  plsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath: limit register, candidate, prime table, remainder unit
  plsp_dpath #(
    .MAX_PRIMES (MAX_PRIMES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .restart   (restart),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .prime     (prime),
    .status    (status)
  );

endmodule

`default_nettype wire
